FILE: hdl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// shared types and constants for the region map table with lru replacement
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CMD_W   = 2;
    localparam int KEY_W   = 48;
    localparam int ADDR_W  = 48;
    localparam int SIZE_W  = 22;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_NO_MEM    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LOOK_END,
        S_DECIDE,
        S_ALLOC,
        S_ALLOC_END,
        S_COMMIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] region_size;
        logic [ADDR_W-1:0] offered_addr;
        logic              offered_ok;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] region_addr;
        logic [SLOT_W-1:0] slot;
        logic              offered_taken;
        logic              free_valid;
        logic [ADDR_W-1:0] free_addr;
    } result_t;

    // table write port: full entry write, time refresh, valid bit update
    typedef struct packed {
        logic              we_all;
        logic              we_time;
        idx_t              addr;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] remote;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
        logic              vld_we;
        idx_t              vld_addr;
        logic              vld_data;
    } tbl_wr_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] remote;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] stamp;
    } tbl_rd_t;

endpackage

FILE: hdl/region_map_table_lru.sv
// ----------------------------------------------------------------------------
// region_map_table_lru
// fully associative key to remote region map with lru replacement
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one command word: read lookup,
//   write lookup-or-allocate, or allocate with key zero, together with the
//   allocator's offered address and the current time stamp
//   output channel out_valid/out_ready returns exactly one result word per
//   command: status, region address, slot, offered_taken and free info
// scans and throughput
//   one sequencer walks the 64 entries through a single compare unit, one
//   entry per cycle, with the compare one entry behind the registered read;
//   read and write run a lookup scan, and a write miss or size mismatch
//   then an allocation scan; allocate runs only the allocation scan and
//   an unused command none; one command word is in work at a time
// reset
//   all valid bits clear at once, no clearing pass; the block is ready
//   right after reset
// stall
//   a finished result sits in the output register, so the next command word
//   is taken while the receiver holds off; the sequencer waits only when it
//   finishes again before that register drains
// ----------------------------------------------------------------------------
module region_map_table_lru
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rmt_pkg::CMD_W-1:0]   command,
    input  logic [rmt_pkg::KEY_W-1:0]   key,
    input  logic [rmt_pkg::SIZE_W-1:0]  region_size,
    input  logic [rmt_pkg::ADDR_W-1:0]  offered_addr,
    input  logic                        offered_ok,
    input  logic [rmt_pkg::TIME_W-1:0]  now,

    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rmt_pkg::STAT_W-1:0]  status,
    output logic [rmt_pkg::ADDR_W-1:0]  region_addr,
    output logic [rmt_pkg::SLOT_W-1:0]  slot,
    output logic                        offered_taken,
    output logic                        free_valid,
    output logic [rmt_pkg::ADDR_W-1:0]  free_addr
);

    rmt_pkg::req_t    req_in;
    rmt_pkg::result_t seq_res;
    logic             seq_res_valid;
    logic             res_take;

    rmt_pkg::idx_t    rd_addr;
    rmt_pkg::tbl_wr_t tbl_wr;
    rmt_pkg::tbl_rd_t tbl_rd;

    logic [rmt_pkg::KEY_W-1:0] cmp_a;
    logic [rmt_pkg::KEY_W-1:0] cmp_b;
    logic                      cmp_eq;
    logic                      cmp_lt;

    // output register parts the sequencer from the receiver
    rmt_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    assign req_in.command      = command;
    assign req_in.key          = key;
    assign req_in.region_size  = region_size;
    assign req_in.offered_addr = offered_addr;
    assign req_in.offered_ok   = offered_ok;
    assign req_in.now          = now;

    rmt_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_in    (req_in),
        .res_valid (seq_res_valid),
        .res_take  (res_take),
        .res       (seq_res),
        .rd_addr   (rd_addr),
        .wr        (tbl_wr),
        .rd        (tbl_rd),
        .cmp_a     (cmp_a),
        .cmp_b     (cmp_b),
        .cmp_eq    (cmp_eq),
        .cmp_lt    (cmp_lt)
    );

    rmt_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .wr      (tbl_wr),
        .rd      (tbl_rd)
    );

    rmt_cmp u_cmp
    (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq),
        .lt (cmp_lt)
    );

    // load the output register when it is empty or draining this cycle
    assign res_take = seq_res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_next       = seq_res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign region_addr   = out_reg.region_addr;
    assign slot          = out_reg.slot;
    assign offered_taken = out_reg.offered_taken;
    assign free_valid    = out_reg.free_valid;
    assign free_addr     = out_reg.free_addr;

endmodule

FILE: hdl/rmt_table.sv
// ----------------------------------------------------------------------------
// rmt_table
// entry storage: key, remote, size and time memories plus valid flops
// ----------------------------------------------------------------------------
module rmt_table
(
    input  logic             clk,
    input  logic             rst_n,
    input  rmt_pkg::idx_t    rd_addr,
    input  rmt_pkg::tbl_wr_t wr,
    output rmt_pkg::tbl_rd_t rd
);

    logic [rmt_pkg::KEY_W-1:0]  key_mem    [rmt_pkg::ENTRIES];
    logic [rmt_pkg::ADDR_W-1:0] remote_mem [rmt_pkg::ENTRIES];
    logic [rmt_pkg::SIZE_W-1:0] size_mem   [rmt_pkg::ENTRIES];
    logic [rmt_pkg::TIME_W-1:0] time_mem   [rmt_pkg::ENTRIES];

    logic [rmt_pkg::ENTRIES-1:0] valid_reg;
    logic                        rd_valid_reg;
    logic [rmt_pkg::KEY_W-1:0]   rd_key_reg;
    logic [rmt_pkg::ADDR_W-1:0]  rd_remote_reg;
    logic [rmt_pkg::SIZE_W-1:0]  rd_size_reg;
    logic [rmt_pkg::TIME_W-1:0]  rd_time_reg;

    // memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr.we_all)
        begin
            key_mem[wr.addr]    <= wr.key;
            remote_mem[wr.addr] <= wr.remote;
            size_mem[wr.addr]   <= wr.size;
        end
        if (wr.we_all || wr.we_time)
        begin
            time_mem[wr.addr] <= wr.stamp;
        end
        rd_key_reg    <= key_mem[rd_addr];
        rd_remote_reg <= remote_mem[rd_addr];
        rd_size_reg   <= size_mem[rd_addr];
        rd_time_reg   <= time_mem[rd_addr];
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.vld_we)
            begin
                valid_reg[wr.vld_addr] <= wr.vld_data;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd.valid  = rd_valid_reg;
    assign rd.key    = rd_key_reg;
    assign rd.remote = rd_remote_reg;
    assign rd.size   = rd_size_reg;
    assign rd.stamp  = rd_time_reg;

endmodule

FILE: hdl/rmt_cmp.sv
// ----------------------------------------------------------------------------
// rmt_cmp
// shared compare unit: key match during lookup, time order during allocation
// ----------------------------------------------------------------------------
module rmt_cmp
(
    input  logic [rmt_pkg::KEY_W-1:0] a,
    input  logic [rmt_pkg::KEY_W-1:0] b,
    output logic                      eq,
    output logic                      lt
);

    assign eq = (a == b);
    assign lt = (a < b);

endmodule

FILE: hdl/rmt_seq.sv
// ----------------------------------------------------------------------------
// rmt_seq
// sequencer: lookup scan, allocation scan and table update for one word
// ----------------------------------------------------------------------------
module rmt_seq
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rmt_pkg::req_t             req_in,
    output logic                      res_valid,
    input  logic                      res_take,
    output rmt_pkg::result_t          res,
    output rmt_pkg::idx_t             rd_addr,
    output rmt_pkg::tbl_wr_t          wr,
    input  rmt_pkg::tbl_rd_t          rd,
    output logic [rmt_pkg::KEY_W-1:0] cmp_a,
    output logic [rmt_pkg::KEY_W-1:0] cmp_b,
    input  logic                      cmp_eq,
    input  logic                      cmp_lt
);

    rmt_pkg::state_t state_reg, state_next;

    rmt_pkg::req_t    req_reg, req_next;
    rmt_pkg::result_t res_reg, res_next;

    rmt_pkg::idx_t cnt_reg, cnt_next;
    logic          pipe_vld_reg, pipe_vld_next;
    rmt_pkg::idx_t pipe_idx_reg, pipe_idx_next;

    logic                       hit_reg, hit_next;
    rmt_pkg::idx_t              hit_idx_reg, hit_idx_next;
    logic [rmt_pkg::ADDR_W-1:0] hit_remote_reg, hit_remote_next;
    logic [rmt_pkg::SIZE_W-1:0] hit_size_reg, hit_size_next;

    logic                       free_found_reg, free_found_next;
    rmt_pkg::idx_t              free_idx_reg, free_idx_next;
    logic [rmt_pkg::TIME_W-1:0] best_time_reg, best_time_next;
    rmt_pkg::idx_t              best_idx_reg, best_idx_next;
    logic [rmt_pkg::ADDR_W-1:0] best_remote_reg, best_remote_next;

    logic                       fv_reg, fv_next;
    logic [rmt_pkg::ADDR_W-1:0] fa_reg, fa_next;

    logic                       last_idx;
    logic                       alloc_phase;
    logic                       look_phase;
    logic                       size_match;
    rmt_pkg::idx_t              pick;
    logic                       fv_now;
    logic [rmt_pkg::ADDR_W-1:0] fa_now;

    assign last_idx    = (cnt_reg == rmt_pkg::idx_t'(rmt_pkg::ENTRIES - 1));
    assign alloc_phase = (state_reg == rmt_pkg::S_ALLOC) || (state_reg == rmt_pkg::S_ALLOC_END);
    assign look_phase  = (state_reg == rmt_pkg::S_LOOK) || (state_reg == rmt_pkg::S_LOOK_END);
    assign size_match  = (hit_size_reg == req_reg.region_size);
    assign pick        = free_found_reg ? free_idx_reg : best_idx_reg;
    assign fv_now      = fv_reg | ~free_found_reg;
    assign fa_now      = free_found_reg ? fa_reg : best_remote_reg;

    // shared compare operands
    assign cmp_a = alloc_phase ? rmt_pkg::KEY_W'(rd.stamp) : rd.key;
    assign cmp_b = alloc_phase ? rmt_pkg::KEY_W'(best_time_reg) : req_reg.key;

    assign rd_addr   = cnt_reg;
    assign in_ready  = (state_reg == rmt_pkg::S_IDLE);
    assign res_valid = (state_reg == rmt_pkg::S_DONE);
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rmt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_in.command == rmt_pkg::CMD_READ ||
                        req_in.command == rmt_pkg::CMD_WRITE)
                    begin
                        state_next = rmt_pkg::S_LOOK;
                    end
                    else if (req_in.command == rmt_pkg::CMD_ALLOC)
                    begin
                        state_next = rmt_pkg::S_ALLOC;
                    end
                    else
                    begin
                        state_next = rmt_pkg::S_DONE;
                    end
                end
            end
            rmt_pkg::S_LOOK:
            begin
                if (last_idx)
                begin
                    state_next = rmt_pkg::S_LOOK_END;
                end
            end
            rmt_pkg::S_LOOK_END:
            begin
                state_next = rmt_pkg::S_DECIDE;
            end
            rmt_pkg::S_DECIDE:
            begin
                if (req_reg.command == rmt_pkg::CMD_WRITE && !(hit_reg && size_match))
                begin
                    state_next = rmt_pkg::S_ALLOC;
                end
                else
                begin
                    state_next = rmt_pkg::S_DONE;
                end
            end
            rmt_pkg::S_ALLOC:
            begin
                if (last_idx)
                begin
                    state_next = rmt_pkg::S_ALLOC_END;
                end
            end
            rmt_pkg::S_ALLOC_END:
            begin
                state_next = rmt_pkg::S_COMMIT;
            end
            rmt_pkg::S_COMMIT:
            begin
                state_next = rmt_pkg::S_DONE;
            end
            rmt_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = rmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rmt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb
    begin
        req_next         = req_reg;
        res_next         = res_reg;
        cnt_next         = cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = cnt_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        hit_remote_next  = hit_remote_reg;
        hit_size_next    = hit_size_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_time_next   = best_time_reg;
        best_idx_next    = best_idx_reg;
        best_remote_next = best_remote_reg;
        fv_next          = fv_reg;
        fa_next          = fa_reg;
        wr               = '0;

        // compare stage, one entry behind the read address
        if (pipe_vld_reg && look_phase)
        begin
            if (rd.valid && cmp_eq && !hit_reg)
            begin
                hit_next        = 1'b1;
                hit_idx_next    = pipe_idx_reg;
                hit_remote_next = rd.remote;
                hit_size_next   = rd.size;
            end
        end
        if (pipe_vld_reg && alloc_phase)
        begin
            if (!rd.valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = pipe_idx_reg;
            end
            // strict less keeps the lowest index on a tie
            if (pipe_idx_reg == '0 || cmp_lt)
            begin
                best_time_next   = rd.stamp;
                best_idx_next    = pipe_idx_reg;
                best_remote_next = rd.remote;
            end
        end

        case (state_reg)
            rmt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = req_in;
                    if (req_in.command == rmt_pkg::CMD_ALLOC)
                    begin
                        req_next.key = '0;
                    end
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    fv_next         = 1'b0;
                    fa_next         = '0;
                    res_next        = '0;
                    res_next.status = rmt_pkg::ST_NOT_FOUND;
                end
            end
            rmt_pkg::S_LOOK, rmt_pkg::S_ALLOC:
            begin
                cnt_next      = cnt_reg + 1'b1;
                pipe_vld_next = 1'b1;
            end
            rmt_pkg::S_DECIDE:
            begin
                cnt_next = '0;
                if (hit_reg)
                begin
                    if (req_reg.command == rmt_pkg::CMD_READ || size_match)
                    begin
                        // hit: refresh time
                        wr.we_time           = 1'b1;
                        wr.addr              = hit_idx_reg;
                        wr.stamp             = req_reg.now;
                        res_next.status      = rmt_pkg::ST_OK;
                        res_next.region_addr = hit_remote_reg;
                        res_next.slot        = rmt_pkg::SLOT_W'(hit_idx_reg);
                    end
                    else
                    begin
                        // size mismatch: release and reallocate
                        fv_next     = 1'b1;
                        fa_next     = hit_remote_reg;
                        wr.vld_we   = 1'b1;
                        wr.vld_addr = hit_idx_reg;
                        wr.vld_data = 1'b0;
                    end
                end
            end
            rmt_pkg::S_COMMIT:
            begin
                wr.vld_we              = 1'b1;
                wr.vld_addr            = pick;
                wr.vld_data            = req_reg.offered_ok;
                wr.we_all              = req_reg.offered_ok;
                wr.addr                = pick;
                wr.key                 = req_reg.key;
                wr.remote              = req_reg.offered_addr;
                wr.size                = req_reg.region_size;
                wr.stamp               = req_reg.now;
                res_next.free_valid    = fv_now;
                res_next.free_addr     = fa_now;
                res_next.offered_taken = req_reg.offered_ok;
                if (req_reg.offered_ok)
                begin
                    res_next.status      = rmt_pkg::ST_OK;
                    res_next.region_addr = req_reg.offered_addr;
                    res_next.slot        = rmt_pkg::SLOT_W'(pick);
                end
                else
                begin
                    res_next.status = rmt_pkg::ST_NO_MEM;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rmt_pkg::S_IDLE;
            cnt_reg        <= '0;
            pipe_vld_reg   <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            fv_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_vld_reg   <= pipe_vld_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            fv_reg         <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        res_reg         <= res_next;
        pipe_idx_reg    <= pipe_idx_next;
        hit_idx_reg     <= hit_idx_next;
        hit_remote_reg  <= hit_remote_next;
        hit_size_reg    <= hit_size_next;
        free_idx_reg    <= free_idx_next;
        best_time_reg   <= best_time_next;
        best_idx_reg    <= best_idx_next;
        best_remote_reg <= best_remote_next;
        fa_reg          <= fa_next;
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for region_map_table_lru: a scoreboard keeps its own
// copy of the 64-entry table with lru replacement and predicts every result
// word; directed words cover the corner cases and random words over a key
// pool larger than the table force lookups, resizes and evictions
// ----------------------------------------------------------------------------
module testbench;

    // spare command code, the block answers it with not found
    localparam logic [rmt_pkg::CMD_W-1:0]  CMD_SPARE   = 2'd3;
    localparam logic [rmt_pkg::SIZE_W-1:0] SIZE_MAX    = 22'd2097152;
    localparam int                         N_ITEMS     = 1200;
    localparam int                         KEY_POOL    = 80;
    localparam int                         HOLD_AT     = 400;
    localparam int                         DRAIN_AT    = 800;
    localparam int                         HOLD_CYCLES = 1500;
    localparam int                         TAIL_CYCLES = 300;

    // ------------------------------------------------------------------------
    // scoreboard: predicted table contents and queue of expected result words
    // ------------------------------------------------------------------------
    class region_map_scoreboard;
        bit                         slot_used[rmt_pkg::ENTRIES];
        logic [rmt_pkg::KEY_W-1:0]  slot_key[rmt_pkg::ENTRIES];
        logic [rmt_pkg::ADDR_W-1:0] slot_remote[rmt_pkg::ENTRIES];
        logic [rmt_pkg::SIZE_W-1:0] slot_size[rmt_pkg::ENTRIES];
        logic [rmt_pkg::TIME_W-1:0] slot_stamp[rmt_pkg::ENTRIES];
        rmt_pkg::result_t           expected_words[$];
        int errors      = 0;
        int checked     = 0;
        int read_hits   = 0;
        int read_misses = 0;
        int evictions   = 0;
        int resized     = 0;
        int no_mem      = 0;
        int ignored     = 0;

        function new();
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int find_key(logic [rmt_pkg::KEY_W-1:0] k);
            for (int i = 0; i < rmt_pkg::ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == k)
                    return i;
            return -1;
        endfunction

        // lowest free slot, else evict the oldest stamp (lowest index on a tie)
        function int claim_slot(logic [rmt_pkg::KEY_W-1:0] k,
                                logic [rmt_pkg::SIZE_W-1:0] sz,
                                logic [rmt_pkg::ADDR_W-1:0] addr, bit ok,
                                logic [rmt_pkg::TIME_W-1:0] stamp,
                                inout bit fv, inout logic [rmt_pkg::ADDR_W-1:0] fa);
            int pick;
            pick = -1;
            for (int i = 0; i < rmt_pkg::ENTRIES && pick < 0; i++)
                if (!slot_used[i])
                    pick = i;
            if (pick < 0)
            begin
                pick = 0;
                for (int i = 1; i < rmt_pkg::ENTRIES; i++)
                    if (slot_stamp[i] < slot_stamp[pick])
                        pick = i;
                fv = 1'b1;
                fa = slot_remote[pick];
                slot_used[pick] = 1'b0;
                evictions++;
            end
            // a refused offer leaves the slot empty, eviction still reported
            if (!ok)
                return -1;
            slot_used[pick]   = 1'b1;
            slot_key[pick]    = k;
            slot_remote[pick] = addr;
            slot_size[pick]   = sz;
            slot_stamp[pick]  = stamp;
            return pick;
        endfunction

        function void note_command(logic [rmt_pkg::CMD_W-1:0] cmd,
                                   logic [rmt_pkg::KEY_W-1:0] k,
                                   logic [rmt_pkg::SIZE_W-1:0] sz,
                                   logic [rmt_pkg::ADDR_W-1:0] addr,
                                   logic ok, logic [rmt_pkg::TIME_W-1:0] stamp);
            rmt_pkg::result_t           r;
            int                         s;
            bit                         fv;
            logic [rmt_pkg::ADDR_W-1:0] fa;
            r        = '0;
            r.status = rmt_pkg::ST_NOT_FOUND;
            fv       = 1'b0;
            fa       = '0;
            case (cmd)
                rmt_pkg::CMD_READ:
                begin
                    s = find_key(k);
                    if (s >= 0)
                    begin
                        slot_stamp[s] = stamp;
                        r.status      = rmt_pkg::ST_OK;
                        r.region_addr = slot_remote[s];
                        r.slot        = s[rmt_pkg::SLOT_W-1:0];
                        read_hits++;
                    end
                    else
                        read_misses++;
                end
                rmt_pkg::CMD_WRITE, rmt_pkg::CMD_ALLOC:
                begin
                    s = (cmd == rmt_pkg::CMD_WRITE) ? find_key(k) : -1;
                    if (cmd == rmt_pkg::CMD_ALLOC)
                        k = '0;
                    if (s >= 0 && slot_size[s] == sz)
                        slot_stamp[s] = stamp;
                    else
                    begin
                        // size change: release the old region, allocate again
                        if (s >= 0)
                        begin
                            fv           = 1'b1;
                            fa           = slot_remote[s];
                            slot_used[s] = 1'b0;
                            resized++;
                        end
                        s = claim_slot(k, sz, addr, ok, stamp, fv, fa);
                        r.offered_taken = (s >= 0);
                    end
                    if (s >= 0)
                    begin
                        r.status      = rmt_pkg::ST_OK;
                        r.region_addr = slot_remote[s];
                        r.slot        = s[rmt_pkg::SLOT_W-1:0];
                    end
                    else
                    begin
                        r.status = rmt_pkg::ST_NO_MEM;
                        no_mem++;
                    end
                end
                default:
                    ignored++;
            endcase
            r.free_valid = fv;
            r.free_addr  = fa;
            expected_words.push_back(r);
        endfunction

        function void compare_field(string name, logic [rmt_pkg::ADDR_W-1:0] exp_v,
                                    logic [rmt_pkg::ADDR_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result_word(logic [rmt_pkg::STAT_W-1:0] st,
                                        logic [rmt_pkg::ADDR_W-1:0] ra,
                                        logic [rmt_pkg::SLOT_W-1:0] sl, logic tk, logic fv,
                                        logic [rmt_pkg::ADDR_W-1:0] fa);
            rmt_pkg::result_t e;
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected, status %h", $time, st);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            checked++;
            compare_field("status", rmt_pkg::ADDR_W'(e.status), rmt_pkg::ADDR_W'(st));
            compare_field("region_addr", e.region_addr, ra);
            compare_field("slot", rmt_pkg::ADDR_W'(e.slot), rmt_pkg::ADDR_W'(sl));
            compare_field("offered_taken", rmt_pkg::ADDR_W'(e.offered_taken),
                          rmt_pkg::ADDR_W'(tk));
            compare_field("free_valid", rmt_pkg::ADDR_W'(e.free_valid),
                          rmt_pkg::ADDR_W'(fv));
            compare_field("free_addr", e.free_addr, fa);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and block under test
    // ------------------------------------------------------------------------
    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [rmt_pkg::CMD_W-1:0]  command;
    logic [rmt_pkg::KEY_W-1:0]  key;
    logic [rmt_pkg::SIZE_W-1:0] region_size;
    logic [rmt_pkg::ADDR_W-1:0] offered_addr;
    logic                       offered_ok;
    logic [rmt_pkg::TIME_W-1:0] now;
    logic                       out_valid;
    logic                       out_ready;
    logic [rmt_pkg::STAT_W-1:0] status;
    logic [rmt_pkg::ADDR_W-1:0] region_addr;
    logic [rmt_pkg::SLOT_W-1:0] slot;
    logic                       offered_taken;
    logic                       free_valid;
    logic [rmt_pkg::ADDR_W-1:0] free_addr;

    // set by the stimulus, served by the receiver with a long stall
    bit                hold_request = 1'b0;

    region_map_scoreboard sb;

    region_map_table_lru DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .key           (key),
        .region_size   (region_size),
        .offered_addr  (offered_addr),
        .offered_ok    (offered_ok),
        .now           (now),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .region_addr   (region_addr),
        .slot          (slot),
        .offered_taken (offered_taken),
        .free_valid    (free_valid),
        .free_addr     (free_addr)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // monitor: both handshakes sampled at the rising edge, before any
    // nonblocking update of that edge lands
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_command(command, key, region_size, offered_addr, offered_ok, now);
            if (out_valid && out_ready)
                sb.check_result_word(status, region_addr, slot, offered_taken,
                                     free_valid, free_addr);
        end
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------
    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic logic [rmt_pkg::SIZE_W-1:0] pick_size();
        logic [rmt_pkg::SIZE_W-1:0] sz;
        case ($urandom_range(0, 5))
            0:       sz = '0;
            1:       sz = SIZE_MAX;
            2:       sz = 22'd4096;
            3:       sz = 22'd65536;
            default: sz = rmt_pkg::SIZE_W'($urandom_range(0, SIZE_MAX));
        endcase
        return sz;
    endfunction

    // offer one command word and hold it until the block takes it
    task automatic send_word(input logic [rmt_pkg::CMD_W-1:0] cmd,
                             input logic [rmt_pkg::KEY_W-1:0] k,
                             input logic [rmt_pkg::SIZE_W-1:0] sz,
                             input logic [rmt_pkg::ADDR_W-1:0] addr,
                             input logic ok, input logic [rmt_pkg::TIME_W-1:0] stamp);
        in_valid     <= 1'b1;
        command      <= cmd;
        key          <= k;
        region_size  <= sz;
        offered_addr <= addr;
        offered_ok   <= ok;
        now          <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: rotating ready pattern, re-picked now and then, plus one
    // long hold-off on request so the block backs up into its input
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        logic [7:0] ready_pattern;
        int         pattern_left;
        ready_pattern = 8'hFF;
        pattern_left  = 0;
        out_ready     = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    ready_pattern = 8'hFF;
                        2:       ready_pattern = 8'($urandom) | 8'h01;
                        3:       ready_pattern = 8'b1000_0001;
                        default: ready_pattern = 8'b0000_0001;
                    endcase
                    pattern_left = $urandom_range(50, 400);
                end
                pattern_left--;
                out_ready <= ready_pattern[0];
                ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender and run control
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [rmt_pkg::KEY_W-1:0]  key_pool[KEY_POOL];
        logic [rmt_pkg::SIZE_W-1:0] size_pool[KEY_POOL];
        logic [rmt_pkg::KEY_W-1:0]  k_a;
        logic [rmt_pkg::KEY_W-1:0]  k_b;
        logic [rmt_pkg::KEY_W-1:0]  k_sel;
        logic [rmt_pkg::CMD_W-1:0]  cmd_sel;
        logic [rmt_pkg::TIME_W-1:0] stamp_cnt;
        logic [rmt_pkg::TIME_W-1:0] stamp;
        int                         counted;
        int                         pick;
        int                         roll;
        int                         burst_left;
        int                         gap;
        bit                         hold_done;
        bit                         drain_done;

        sb           = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = rmt_pkg::CMD_READ;
        key          = '0;
        region_size  = '0;
        offered_addr = '0;
        offered_ok   = 1'b0;
        now          = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        // directed words on a fresh table
        k_a = 48'h0000_1234_5678;
        k_b = 48'h8000_0000_0001;
        // read miss on an empty table, then the unused command code
        send_word(rmt_pkg::CMD_READ,  '0, '0, '0, 1'b0, '0);
        send_word(CMD_SPARE, '1, SIZE_MAX, '1, 1'b1, '1);
        // all-ones key and size 2^21 (SIZE_MAX), then key zero with zero size
        send_word(rmt_pkg::CMD_WRITE, '1, SIZE_MAX, '1, 1'b1, '1);
        send_word(rmt_pkg::CMD_WRITE, '0, '0, '0, 1'b1, '0);
        send_word(rmt_pkg::CMD_READ,  '1, '0, rand48(), 1'b0, 32'd3);
        // write hit with equal size: only the stamp moves
        send_word(rmt_pkg::CMD_WRITE, '1, SIZE_MAX, rand48(), 1'b1, 32'd5);
        send_word(rmt_pkg::CMD_WRITE, k_a, 22'd4096, rand48(), 1'b1, 32'd10);
        send_word(rmt_pkg::CMD_WRITE, k_b, 22'd8192, rand48(), 1'b1, 32'd11);
        // resize refused by the allocator leaves a hole
        send_word(rmt_pkg::CMD_WRITE, k_a, 22'd16384, rand48(), 1'b0, 32'd12);
        // resize moves the entry into that earlier hole
        send_word(rmt_pkg::CMD_WRITE, k_b, 22'd4096, rand48(), 1'b1, 32'd13);
        send_word(rmt_pkg::CMD_READ,  k_a, '0, '0, 1'b1, 32'd14);
        // miss with no memory and free slots, nothing evicted
        send_word(rmt_pkg::CMD_WRITE, rand48(), 22'd100, rand48(), 1'b0, 32'd15);
        // allocate duplicates key zero, key field ignored
        send_word(rmt_pkg::CMD_ALLOC, k_a, 22'd512, rand48(), 1'b1, 32'd16);
        send_word(rmt_pkg::CMD_READ,  '0, '0, '0, 1'b0, 32'd17);
        send_word(rmt_pkg::CMD_WRITE, '0, '0, rand48(), 1'b1, 32'd18);
        send_word(rmt_pkg::CMD_ALLOC, '1, SIZE_MAX, '1, 1'b1, '1);
        send_word(rmt_pkg::CMD_ALLOC, '0, '0, '0, 1'b0, '0);
        send_word(CMD_SPARE, '0, '0, '0, 1'b0, '0);

        // random words over a key pool larger than the table so it fills up
        foreach (key_pool[i])
        begin
            key_pool[i]  = (i == 0) ? '0 : rand48();
            size_pool[i] = pick_size();
        end
        stamp_cnt  = 32'd100;
        counted    = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        burst_left = $urandom_range(1, 30);
        while (counted < N_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                cmd_sel = CMD_SPARE;
            else if (roll < 37)
                cmd_sel = rmt_pkg::CMD_READ;
            else if (roll < 90)
                cmd_sel = rmt_pkg::CMD_WRITE;
            else
                cmd_sel = rmt_pkg::CMD_ALLOC;
            pick  = $urandom_range(0, KEY_POOL - 1);
            k_sel = ($urandom_range(0, 9) == 0) ? rand48() : key_pool[pick];
            // occasional size change per key gives resizes on later writes
            if ($urandom_range(0, 7) == 0)
                size_pool[pick] = pick_size();
            // stamps mostly climb, step of zero makes lru ties
            if ($urandom_range(0, 19) == 0)
                stamp = $urandom;
            else
            begin
                stamp_cnt = stamp_cnt + $urandom_range(0, 3);
                stamp     = stamp_cnt;
            end
            send_word(cmd_sel, k_sel, size_pool[pick], rand48(),
                      $urandom_range(0, 9) != 0, stamp);
            if (cmd_sel != CMD_SPARE)
                counted++;

            if (counted >= HOLD_AT && !hold_done)
            begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end

            if (counted >= DRAIN_AT && !drain_done)
            begin
                // sender pauses until every expected word is back
                drain_done = 1'b1;
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            else
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 :
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 160) :
                                                        $urandom_range(1, 40);
                    if (gap != 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap)
                            @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 30);
                end
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("checked %0d result words: %0d read hits, %0d read misses, %0d unused codes",
                 sb.checked, sb.read_hits, sb.read_misses, sb.ignored);
        $display("lru evictions %0d, size changes %0d, no-memory results %0d, errors %0d",
                 sb.evictions, sb.resized, sb.no_mem, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin : watchdog
        #20000000;
        $display("%0t: timeout, %0d result words still expected", $time, sb.pending());
        $display("testbench failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/rmt_pkg.sv
hdl/rmt_table.sv
hdl/rmt_cmp.sv
hdl/rmt_seq.sv
hdl/region_map_table_lru.sv
dv/testbench.sv
